// ----- hw/rtl/tlbp_pkg.sv -----
// Shared types, character codes and time-mark helpers for the line block packer.
`default_nettype none

package tlbp_pkg;

   localparam int BLOCK_BYTES_DEF = 512;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [15:0] FLUSH_TIMEOUT_RST = 16'd1000;
   localparam logic [15:0] IDLE_MAX          = 16'hFFFF;

   // register index taken from paddr[2]
   localparam logic REG_FLUSH_TIMEOUT = 1'b0;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   // position of each byte in a line-end run: the line feed, then the time mark
   localparam logic [3:0] POS_DATA    = 4'd0;
   localparam logic [3:0] POS_OPEN    = 4'd1;
   localparam logic [3:0] POS_H_TENS  = 4'd2;
   localparam logic [3:0] POS_H_ONES  = 4'd3;
   localparam logic [3:0] POS_COLON_A = 4'd4;
   localparam logic [3:0] POS_M_TENS  = 4'd5;
   localparam logic [3:0] POS_M_ONES  = 4'd6;
   localparam logic [3:0] POS_COLON_B = 4'd7;
   localparam logic [3:0] POS_S_TENS  = 4'd8;
   localparam logic [3:0] POS_S_ONES  = 4'd9;
   localparam logic [3:0] POS_CLOSE   = 4'd10;
   localparam logic [3:0] POS_LAST    = 4'd11;

   typedef enum logic {
      OP_BYTE,
      OP_PAD
   } op_type;

   // digits[0] hour tens ... digits[5] second ones
   typedef struct packed {
      op_type          op;
      logic [7:0]      data;
      logic            line_end;
      logic            end_valid;
      logic [3:0]      end_idx;
      logic [5:0][3:0] digits;
      logic [9:0]      pad_len;
   } cmd_type;

   // two decimal digits of a value up to 63, tens in the upper nibble
   function automatic logic [7:0] two_digits(input logic [5:0] v);
      logic [3:0] tens;
      logic [5:0] ones;
      if (v >= 6'd60) begin
         tens = 4'd6;
      end else if (v >= 6'd50) begin
         tens = 4'd5;
      end else if (v >= 6'd40) begin
         tens = 4'd4;
      end else if (v >= 6'd30) begin
         tens = 4'd3;
      end else if (v >= 6'd20) begin
         tens = 4'd2;
      end else if (v >= 6'd10) begin
         tens = 4'd1;
      end else begin
         tens = 4'd0;
      end
      ones = v - (6'(tens) * 6'd10);
      return {tens, ones[3:0]};
   endfunction

   function automatic logic [7:0] mark_char(input logic [3:0] pos,
                                            input logic [5:0][3:0] digits);
      logic [7:0] ch;
      case (pos)
         POS_OPEN:    ch = CH_OPEN;
         POS_H_TENS:  ch = CH_ZERO + 8'(digits[0]);
         POS_H_ONES:  ch = CH_ZERO + 8'(digits[1]);
         POS_COLON_A: ch = CH_COLON;
         POS_M_TENS:  ch = CH_ZERO + 8'(digits[2]);
         POS_M_ONES:  ch = CH_ZERO + 8'(digits[3]);
         POS_COLON_B: ch = CH_COLON;
         POS_S_TENS:  ch = CH_ZERO + 8'(digits[4]);
         POS_S_ONES:  ch = CH_ZERO + 8'(digits[5]);
         POS_CLOSE:   ch = CH_CLOSE;
         default:     ch = CH_SPACE;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tlbp_front.sv -----
// Front end: accepts input transactions, tracks fill and idle state, issues commands.
`default_nettype none

module tlbp_front #(
   parameter int BLOCK_BYTES = tlbp_pkg::BLOCK_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [1:0]        kind,
   input  wire logic [7:0]        data_byte,
   input  wire logic [4:0]        hour,
   input  wire logic [5:0]        minute,
   input  wire logic [5:0]        second,
   input  wire logic [15:0]       flush_timeout,
   input  wire logic              queue_full,
   output logic                   push,
   output tlbp_pkg::cmd_type      cmd
);

   localparam int FW = $clog2(BLOCK_BYTES);
   localparam logic [FW:0] BLOCK_LEN  = (FW+1)'(BLOCK_BYTES);
   localparam logic [FW:0] RUN_LONG   = (FW+1)'(12);
   localparam logic [FW:0] RUN_SHORT  = (FW+1)'(1);

   logic [FW-1:0] fill_ff, fill_in;
   logic          prev_cr_ff, prev_cr_in;
   logic [15:0]   idle_ff, idle_in;
   logic [15:0]   idle_inc;
   logic [FW:0]   room;
   logic [FW:0]   run_len;
   logic          line_end;
   logic          accept;
   logic          issue;
   logic [7:0]    hd, md, sd;

   assign accept   = in_valid && !queue_full;
   assign room     = BLOCK_LEN - {1'b0, fill_ff};
   assign line_end = prev_cr_ff && (data_byte == tlbp_pkg::CH_LF);
   assign run_len  = line_end ? RUN_LONG : RUN_SHORT;
   assign idle_inc = (idle_ff == tlbp_pkg::IDLE_MAX) ? idle_ff : idle_ff + 16'd1;
   assign hd = tlbp_pkg::two_digits({1'b0, hour});
   assign md = tlbp_pkg::two_digits(minute);
   assign sd = tlbp_pkg::two_digits(second);

   always_comb begin
      fill_in    = fill_ff;
      prev_cr_in = prev_cr_ff;
      idle_in    = idle_ff;
      issue      = 1'b0;
      cmd.op        = tlbp_pkg::OP_BYTE;
      cmd.data      = data_byte;
      cmd.line_end  = line_end;
      cmd.end_valid = 1'b0;
      cmd.end_idx   = 4'd0;
      cmd.digits    = {sd[3:0], sd[7:4], md[3:0], md[7:4], hd[3:0], hd[7:4]};
      cmd.pad_len   = 10'(room);
      case (kind)
         tlbp_pkg::KIND_BYTE: begin
            issue = 1'b1;
            // a block closes at most once per run since blocks exceed the run
            if (room <= run_len) begin
               cmd.end_valid = 1'b1;
               cmd.end_idx   = 4'(room - RUN_SHORT);
               fill_in       = FW'(run_len - room);
            end else begin
               fill_in = FW'({1'b0, fill_ff} + run_len);
            end
            idle_in    = 16'd0;
            prev_cr_in = (data_byte == tlbp_pkg::CH_CR);
         end
         tlbp_pkg::KIND_TICK: begin
            idle_in = idle_inc;
            if ((idle_inc > flush_timeout) && (fill_ff != '0)) begin
               issue   = 1'b1;
               cmd.op  = tlbp_pkg::OP_PAD;
               fill_in = '0;
            end
         end
         tlbp_pkg::KIND_FLUSH: begin
            if (fill_ff != '0) begin
               issue   = 1'b1;
               cmd.op  = tlbp_pkg::OP_PAD;
               fill_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign push = accept && issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         prev_cr_ff <= 1'b0;
         idle_ff    <= 16'd0;
      end else if (accept) begin
         fill_ff    <= fill_in;
         prev_cr_ff <= prev_cr_in;
         idle_ff    <= idle_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/tlbp_queue.sv -----
// Short command queue between the front and back ends.
`default_nettype none

module tlbp_queue #(
   parameter int DEPTH = tlbp_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tlbp_pkg::cmd_type push_data,
   input  wire logic              pop,
   output tlbp_pkg::cmd_type      head,
   output logic                   empty,
   output logic                   full
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

   tlbp_pkg::cmd_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == COUNT_FULL);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/tlbp_back.sv -----
// Back end: expands queued commands into result transactions, one per cycle while out_stall is low.
`default_nettype none

module tlbp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tlbp_pkg::cmd_type head,
   input  wire logic              empty,
   output logic                   pop,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output logic [7:0]             out_byte,
   output logic [9:0]             repeat_res,
   output logic                   block_end,
   output logic                   last
);

   logic       valid_ff;
   logic [3:0] pos_ff;
   logic [7:0] byte_ff, byte_in;
   logic [9:0] repeat_ff, repeat_in;
   logic       end_ff, end_in;
   logic       last_ff, last_in;
   logic       advance;
   logic       take;
   logic       is_pad;

   assign advance = !valid_ff || !out_stall;
   assign take    = advance && !empty;
   assign is_pad  = (head.op == tlbp_pkg::OP_PAD);

   always_comb begin
      if (is_pad) begin
         byte_in   = tlbp_pkg::CH_SPACE;
         repeat_in = head.pad_len;
         end_in    = 1'b1;
         last_in   = 1'b1;
      end else begin
         byte_in   = (pos_ff == tlbp_pkg::POS_DATA) ? head.data
                                                   : tlbp_pkg::mark_char(pos_ff, head.digits);
         repeat_in = 10'd1;
         end_in    = head.end_valid && (head.end_idx == pos_ff);
         last_in   = !head.line_end || (pos_ff == tlbp_pkg::POS_LAST);
      end
   end

   assign pop = take && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= tlbp_pkg::POS_DATA;
      end else begin
         if (advance) begin
            valid_ff <= !empty;
         end
         if (take) begin
            pos_ff <= last_in ? tlbp_pkg::POS_DATA : pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff   <= byte_in;
         repeat_ff <= repeat_in;
         end_ff    <= end_in;
         last_ff   <= last_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_byte   = byte_ff;
   assign repeat_res = repeat_ff;
   assign block_end  = end_ff;
   assign last       = last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/timestamped_line_block_packer_core.sv -----
// Top level of the timestamped line block packer: front end, command queue, back end, CSR.
//
// Input channel (req_*): one transaction per item; kind 0 is a log byte, 1 a tick,
// 2 a power-loss flush, 3 is ignored. hour/minute/second feed the time mark.
// Result channel (rsp_*): one transaction per emitted byte run. A byte yields one
// result; a CR followed by LF yields twelve (the LF and "(HH:MM:SS) "); a padding
// flush yields one space run whose rsp_repeat_res closes the block. rsp_last marks
// the final result of an item, rsp_block_end the result that completes a block.
// With the queue empty, an accepted item is first written into the command queue and
// then loaded into the back end's output register, which raises rsp_valid.
// Throughput: one result per cycle while rsp_stall is low, set by the back end's output
// register, so a line end occupies the back end for twelve results and a plain byte for
// one. The front end takes one item per cycle while the command queue has room.
// Stall: while rsp_stall is high the result register holds; the queue fills and
// then req_stall rises. Items that cause no result never enter the queue.
// Reset (synchronous): clears fill, idle count, CR flag and queue; flush_timeout
// returns to 1000. CSR: register 0 at byte address 0 is flush_timeout; pready is
// always high; write only while the block is idle.
`default_nettype none

module timestamped_line_block_packer_core #(
   parameter int BLOCK_BYTES = tlbp_pkg::BLOCK_BYTES_DEF,
   parameter int QUEUE_DEPTH = tlbp_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [4:0]  req_hour,
   input  wire logic [5:0]  req_minute,
   input  wire logic [5:0]  req_second,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic [9:0]       rsp_repeat_res,
   output logic             rsp_block_end,
   output logic             rsp_last,
   // configuration port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [15:0]       flush_timeout_ff;
   logic              cfg_write;
   logic              q_push, q_pop, q_empty, q_full;
   tlbp_pkg::cmd_type q_in, q_head;

   // CSR: one register, index taken from paddr[2]
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite
                      && (paddr[2] == tlbp_pkg::REG_FLUSH_TIMEOUT);
   assign prdata    = (paddr[2] == tlbp_pkg::REG_FLUSH_TIMEOUT) ?
                      {16'd0, flush_timeout_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_timeout_ff <= tlbp_pkg::FLUSH_TIMEOUT_RST;
      end else if (cfg_write) begin
         flush_timeout_ff <= pwdata[15:0];
      end
   end

   // hold off the source whenever the queue cannot take a command
   assign req_stall = q_full;

   tlbp_front #(
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .kind         (req_kind),
      .data_byte    (req_data_byte),
      .hour         (req_hour),
      .minute       (req_minute),
      .second       (req_second),
      .flush_timeout(flush_timeout_ff),
      .queue_full   (q_full),
      .push         (q_push),
      .cmd          (q_in)
   );

   tlbp_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   // expand each command into its results, advancing only when the output drains
   tlbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .empty     (q_empty),
      .pop       (q_pop),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_byte  (rsp_out_byte),
      .repeat_res(rsp_repeat_res),
      .block_end (rsp_block_end),
      .last      (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // a run longer than one byte is always a closing space pad
   a_pad_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_repeat_res != 10'd1) |->
         (rsp_out_byte == tlbp_pkg::CH_SPACE) && rsp_block_end && rsp_last)
      else $error("multi-byte run is not a closing pad");

   // results of one item follow without gaps once the receiver takes them
   a_run_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last && !rsp_stall |=> rsp_valid)
      else $error("gap inside the results of one item");

   // a command is only retired from a non-empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty command queue");

   // an accepted byte always leaves a command behind
   a_byte_queued: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == tlbp_pkg::KIND_BYTE) |=> !q_empty)
      else $error("accepted byte produced no command");
`endif

endmodule

`default_nettype wire
